/* sv/assert_macros.svh */
// Assertion helper macros shared by the pan tracker RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define PTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pan tracker assertion failed");
// Next-cycle implication.
`define PTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pan tracker assertion failed");
`else
`define PTS_ASSERT_NOW(lbl, ante, cons)
`define PTS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/pts_pkg.sv */
// Shared types and constants for the pan tracking servo frame block.
// No dependencies.
package pts_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_MOVE_TIME    = 2'd1,
        CFG_HEADER_BYTE  = 2'd2,
        CFG_COMMAND_BYTE = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [11:0] frame_width;
        logic [15:0] move_time;
        logic [7:0]  header_byte;
        logic [7:0]  command_byte;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [15:0] MOVE_TIME_RESET    = 16'd100;
    localparam logic [7:0]  HEADER_BYTE_RESET  = 8'd85;
    localparam logic [7:0]  COMMAND_BYTE_RESET = 8'd1;

    localparam int QUEUE_DEPTH = 2;

    // tracking loop
    localparam logic [7:0]  PAN_RESET = 8'd90;
    localparam logic [7:0]  PAN_MAX   = 8'd180;
    localparam logic [12:0] DEADBAND  = 13'd15;
    // x/75 == (x*6991)>>19 for x below 8192
    localparam logic [12:0] RECIP_75    = 13'd6991;
    localparam int          RECIP_SHIFT = 19;

    // position: pan*25/6 == (pan*25*5462)>>15 for pan*25 below 8192
    localparam logic [17:0] POS_SCALE = 18'd136550;
    localparam int          POS_SHIFT = 15;
    localparam logic [10:0] POS_MAX   = 11'd1000;

    // frame layout
    localparam logic [7:0] SERVO_ID     = 8'd1;
    localparam logic [7:0] LENGTH_FIELD = 8'd7;
    localparam int         FRAME_LEN    = 10;
    localparam int         BYTE_IDX_W   = 4;
    localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(FRAME_LEN - 1);

    // byte positions
    localparam int B_HDR0 = 0;
    localparam int B_HDR1 = 1;
    localparam int B_ID   = 2;
    localparam int B_LEN  = 3;
    localparam int B_CMD  = 4;
    localparam int B_POSL = 5;
    localparam int B_POSH = 6;
    localparam int B_MTL  = 7;
    localparam int B_MTH  = 8;
    localparam int B_SUM  = 9;

endpackage

/* sv/pan_tracking_servo_frame.sv */
// Pan tracker with bus servo frame output. A box word is held in the front
// register, pushed into the queue, then loaded into the back end's frame
// store. Sustained box rate is set by the back end sending the ten-byte
// frame one byte a cycle while out_stall is low. Reset (rst_n low, async) sets
// pan to 90, the registers to their defaults and empties the queue.
//
// Structure:
//   pts_front  - one register stage: centre/error and a reciprocal multiply
//                for error/75, then the pan update and saturation as the
//                result is pushed to the queue.
//   pts_queue  - short queue of pan angles, so a new box is taken while a
//                frame is still going out.
//   pts_back   - turns a pan angle into a frame (position scale and clamp,
//                config fields, checksum) and sends it out, byte by byte.
// Configuration is a plain write port; writes are expected only when idle.

module pan_tracking_servo_frame #(
    parameter int QUEUE_DEPTH = pts_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // box input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [11:0]                   box_left,
    input  logic [11:0]                   box_width,
    // frame output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    frame_byte,
    output logic                          frame_last,
    // configuration writes
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0] cfg_data
);

    pts_pkg::cfg_t          cfg_reg;
    pts_pkg::queue_status_t q_status;
    logic                   q_push;
    logic                   q_pop;
    logic [7:0]             q_pan;
    logic [7:0]             q_head;

    // register file; index values outside the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= pts_pkg::FRAME_WIDTH_RESET;
            cfg_reg.move_time    <= pts_pkg::MOVE_TIME_RESET;
            cfg_reg.header_byte  <= pts_pkg::HEADER_BYTE_RESET;
            cfg_reg.command_byte <= pts_pkg::COMMAND_BYTE_RESET;
        end
        else if (cfg_write)
        begin
            case (pts_pkg::cfg_index_t'(cfg_index))
                pts_pkg::CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[11:0];
                pts_pkg::CFG_MOVE_TIME:    cfg_reg.move_time    <= cfg_data[15:0];
                pts_pkg::CFG_HEADER_BYTE:  cfg_reg.header_byte  <= cfg_data[7:0];
                pts_pkg::CFG_COMMAND_BYTE: cfg_reg.command_byte <= cfg_data[7:0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: classify the box and track pan
    pts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .box_left    (box_left),
        .box_width   (box_width),
        .frame_width (cfg_reg.frame_width),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_pan       (q_pan)
    );

    // decoupling queue
    pts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_pan),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    // back: frame build and byte serialiser
    pts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_status   (q_status),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

endmodule

/* sv/pts_front.sv */
// Front end: takes box words, works out the pan correction, keeps the pan angle.
// Depends on pts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pts_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [11:0]           box_left,
    input  logic [11:0]           box_width,
    input  logic [11:0]           frame_width,
    input  pts_pkg::queue_status_t q_status,
    output logic                  q_push,
    output logic [7:0]            q_pan
);

    logic               a_valid_reg, a_valid_next;
    logic [6:0]         a_q_reg;
    logic               a_neg_reg;
    logic               a_apply_reg;
    logic [7:0]         pan_reg, pan_next;

    logic               accept;
    logic [12:0]        centre;
    logic signed [13:0] err;
    logic [13:0]        err_neg;
    logic               neg;
    logic [12:0]        mag;
    logic [25:0]        prod;
    logic signed [9:0]  pan_sum;
    logic signed [9:0]  q_ext;

    assign in_stall = a_valid_reg && q_status.full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = a_valid_reg && !q_status.full;

    // centre and error against half the frame width
    always_comb
    begin
        centre  = {1'b0, box_left} + {2'b00, box_width[11:1]};
        err     = $signed({1'b0, centre}) - $signed({3'b000, frame_width[11:1]});
        err_neg = 14'(-err);
        neg     = err[13];
        mag     = neg ? err_neg[12:0] : err[12:0];
        prod    = 26'(mag) * 26'(pts_pkg::RECIP_75);
    end

    // apply the correction (only outside the deadband), truncated toward zero, then saturate
    always_comb
    begin
        q_ext   = $signed({3'b000, a_q_reg});
        pan_sum = $signed({2'b00, pan_reg});
        if (a_apply_reg)
        begin
            pan_sum = a_neg_reg ? pan_sum + q_ext : pan_sum - q_ext;
        end
        if (pan_sum < 0)
        begin
            pan_next = 8'd0;
        end
        else if (pan_sum > $signed({2'b00, pts_pkg::PAN_MAX}))
        begin
            pan_next = pts_pkg::PAN_MAX;
        end
        else
        begin
            pan_next = pan_sum[7:0];
        end
    end

    assign q_pan = pan_next;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            pan_reg     <= pts_pkg::PAN_RESET;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (q_push)
            begin
                pan_reg <= pan_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_q_reg     <= prod[pts_pkg::RECIP_SHIFT +: 7];
            a_neg_reg   <= neg;
            a_apply_reg <= mag > pts_pkg::DEADBAND;
        end
    end

    `PTS_ASSERT_NOW(a_pan_range, 1'b1, pan_reg <= pts_pkg::PAN_MAX)

endmodule

/* sv/pts_queue.sv */
// Short queue of pan angles between the front and back ends.
// Depends on pts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pts_queue #(
    parameter int DEPTH = pts_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [7:0]             push_data,
    input  logic                   pop,
    output logic [7:0]             head,
    output pts_pkg::queue_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [7:0]       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head         = mem[rd_ptr_reg];
    assign status.full  = count_reg == CNT_W'(DEPTH);
    assign status.empty = count_reg == '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `PTS_ASSERT_NOW(a_no_overflow, push, !status.full)
    `PTS_ASSERT_NOW(a_no_underflow, pop, !status.empty)

endmodule

/* sv/pts_back.sv */
// Back end: builds the servo frame from a pan angle and sends it out a byte at a time.
// Depends on pts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pts_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pts_pkg::cfg_t          cfg,
    input  pts_pkg::queue_status_t q_status,
    input  logic [7:0]             q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             frame_byte,
    output logic                   frame_last
);

    logic [7:0]                     store_reg [pts_pkg::FRAME_LEN];
    logic [pts_pkg::BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic                           valid_reg, valid_next;

    logic        take;
    logic        last_take;
    logic        load;
    logic [25:0] pos_prod;
    logic [10:0] pos_raw;
    logic [9:0]  pos;
    logic [7:0]  sum;

    assign out_valid  = valid_reg;
    assign frame_byte = store_reg[idx_reg];
    assign frame_last = idx_reg == pts_pkg::LAST_IDX;

    assign take      = valid_reg && !out_stall;
    assign last_take = take && frame_last;
    assign load      = !q_status.empty && (!valid_reg || last_take);
    assign q_pop     = load;

    always_comb
    begin
        pos_prod = 26'(q_head) * 26'(pts_pkg::POS_SCALE);
        pos_raw  = pos_prod[pts_pkg::POS_SHIFT +: 11];
        pos      = (pos_raw > pts_pkg::POS_MAX) ? pts_pkg::POS_MAX[9:0] : pos_raw[9:0];
    end

    // checksum over id..move time high, refreshed every cycle; the bytes it
    // covers are steady long before the last byte goes out
    always_comb
    begin
        sum = 8'd0;
        for (int k = pts_pkg::B_ID; k <= pts_pkg::B_MTH; k++)
        begin
            sum = sum + store_reg[k];
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = '0;
            valid_next = 1'b1;
        end
        else if (last_take)
        begin
            idx_next   = '0;
            valid_next = 1'b0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            store_reg[pts_pkg::B_HDR0] <= cfg.header_byte;
            store_reg[pts_pkg::B_HDR1] <= cfg.header_byte;
            store_reg[pts_pkg::B_ID]   <= pts_pkg::SERVO_ID;
            store_reg[pts_pkg::B_LEN]  <= pts_pkg::LENGTH_FIELD;
            store_reg[pts_pkg::B_CMD]  <= cfg.command_byte;
            store_reg[pts_pkg::B_POSL] <= pos[7:0];
            store_reg[pts_pkg::B_POSH] <= {6'd0, pos[9:8]};
            store_reg[pts_pkg::B_MTL]  <= cfg.move_time[7:0];
            store_reg[pts_pkg::B_MTH]  <= cfg.move_time[15:8];
        end
        store_reg[pts_pkg::B_SUM] <= ~sum;
    end

    `PTS_ASSERT_NOW(a_idx_range, valid_reg, idx_reg <= pts_pkg::LAST_IDX)
    `PTS_ASSERT_NEXT(a_drain, last_take && q_status.empty, !valid_reg)
    `PTS_ASSERT_NEXT(a_restart, load, valid_reg && idx_reg == '0)

endmodule
